### hdl/mfnp_pkg.sv
`timescale 1ns / 1ps
// Package for the Morton face-neighbor probe: field widths, face codes and
// the packed request / response transaction types. No dependencies.
package mfnp_pkg;

  // Per-axis coordinate width and derived field widths
  localparam int AXIS_BITS = 10;
  localparam int CODE_W    = 3 * AXIS_BITS;
  localparam int LEVEL_W   = 4;
  localparam int FACE_W    = 3;
  localparam int COARSE_W  = CODE_W - 3;

  // Face codes
  localparam logic [FACE_W-1:0] FACE_X_NEG = 3'd0;
  localparam logic [FACE_W-1:0] FACE_X_POS = 3'd1;
  localparam logic [FACE_W-1:0] FACE_Y_NEG = 3'd2;
  localparam logic [FACE_W-1:0] FACE_Y_POS = 3'd3;
  localparam logic [FACE_W-1:0] FACE_Z_NEG = 3'd4;
  localparam logic [FACE_W-1:0] FACE_Z_POS = 3'd5;

  typedef struct packed {
    logic [CODE_W-1:0]  node_code;
    logic [LEVEL_W-1:0] node_level;
    logic [FACE_W-1:0]  face;
  } probe_req_t;

  typedef struct packed {
    logic [CODE_W-1:0]   neighbour_code;
    logic                neighbour_valid;
    logic [COARSE_W-1:0] coarser_code;
    logic                coarser_valid;
  } probe_rsp_t;

endpackage

### hdl/morton_face_neighbour_probe.sv
`timescale 1ns / 1ps
// Morton face-neighbor probe for an octree of blocks.
// A probe transaction carries a 30-bit xyz Morton code (x in bit 0 of each
// triple), the block level (0..10, larger values act as 10) and a face code
// (0 x-, 1 x+, 2 y-, 3 y+, 4 z-, 5 z+). Each probe gives exactly one result
// transaction: the same-level neighbor code with its valid bit, and the
// one-level-coarser code (neighbor >> 3), valid when level is above zero.
// Out-of-domain neighbors, codes beyond their level and faces 6/7 give an
// all-zero result.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low. A probe passes an input register, then the decode, step and
// re-encode logic feeding the result register. Throughput is one probe per
// cycle while result_stall stays low, set by that register-to-register pass.
// A skid register behind the result register absorbs one result while the
// receiver stalls; probe_stall rises once the input register and skid are
// both occupied, so at most three probes are in flight.
// Synchronous reset empties all stages; no probe is accepted during reset.
// Depends on mfnp_pkg, mfnp_step and mfnp_out_buf.
module morton_face_neighbour_probe
  import mfnp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       probe_valid,
  output logic       probe_stall,
  input  probe_req_t probe,
  output logic       result_valid,
  input  logic       result_stall,
  output probe_rsp_t result
);

  logic       stage_valid;
  probe_req_t stage;
  probe_rsp_t step_rsp;
  logic       buf_full;
  logic       push;
  logic       accept;

  // Input register advances into the result buffer unless the skid is full
  assign push        = stage_valid && !buf_full;
  assign probe_stall = stage_valid && buf_full;
  assign accept      = probe_valid && !probe_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept || (stage_valid && !push);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= probe;
    end
  end

  // Neighbor computation
  mfnp_step u_step (
    .req (stage),
    .rsp (step_rsp)
  );

  // Result register with skid
  mfnp_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (step_rsp),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Skid only fills behind an occupied output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    buf_full |-> result_valid)
    else $error("skid register holds data while output register is empty");

  // An accepted probe always lands in the input register
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    accept |=> stage_valid)
    else $error("accepted probe lost");

  // Coarser candidate only exists with a valid neighbor and matches it
  a_coarse_consistent: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.coarser_valid) |->
      (result.neighbour_valid &&
       result.coarser_code == result.neighbour_code[CODE_W-1:3]))
    else $error("coarser code inconsistent with neighbor code");

  // Out-of-domain results are all zero
  a_zero_when_invalid: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.neighbour_valid) |->
      (result.neighbour_code == '0 && result.coarser_code == '0 &&
       !result.coarser_valid))
    else $error("out-of-domain result not cleared");

endmodule

### hdl/mfnp_step.sv
`timescale 1ns / 1ps
// Combinational neighbor computation: de-interleave, bound check, step one
// axis, re-interleave. Depends on mfnp_pkg.
module mfnp_step
  import mfnp_pkg::*;
(
  input  probe_req_t req,
  output probe_rsp_t rsp
);

  // Pull every third bit of the code, starting at bit 0
  function automatic logic [AXIS_BITS-1:0] gather(input logic [CODE_W-1:0] c);
    logic [AXIS_BITS-1:0] r;
    for (int i = 0; i < AXIS_BITS; i++) r[i] = c[3*i];
    return r;
  endfunction

  // Spread a coordinate onto every third bit
  function automatic logic [CODE_W-1:0] spread(input logic [AXIS_BITS-1:0] v);
    logic [CODE_W-1:0] r;
    r = '0;
    for (int i = 0; i < AXIS_BITS; i++) r[3*i] = v[i];
    return r;
  endfunction

  logic [LEVEL_W-1:0]   lev;
  logic [AXIS_BITS-1:0] top;
  logic [AXIS_BITS-1:0] cx, cy, cz;
  logic [AXIS_BITS-1:0] nx, ny, nz;
  logic                 in_span;
  logic                 ok;
  logic [CODE_W-1:0]    nb;

  // Saturate level and build the span limit 2^level-1
  always_comb begin
    if (req.node_level > LEVEL_W'(AXIS_BITS)) begin
      lev = LEVEL_W'(AXIS_BITS);
    end else begin
      lev = req.node_level;
    end
    top = ~({AXIS_BITS{1'b1}} << lev);
  end

  // Decode coordinates and check the block lies inside its level
  assign cx = gather(req.node_code);
  assign cy = gather(req.node_code >> 1);
  assign cz = gather(req.node_code >> 2);
  assign in_span = (cx <= top) && (cy <= top) && (cz <= top);

  // Step the face axis; edge of domain or unused face gives no neighbor
  always_comb begin
    nx = cx;
    ny = cy;
    nz = cz;
    ok = in_span;
    unique case (req.face)
      FACE_X_NEG: begin
        ok = ok && (cx != '0);
        nx = cx - 1'b1;
      end
      FACE_X_POS: begin
        ok = ok && (cx < top);
        nx = cx + 1'b1;
      end
      FACE_Y_NEG: begin
        ok = ok && (cy != '0);
        ny = cy - 1'b1;
      end
      FACE_Y_POS: begin
        ok = ok && (cy < top);
        ny = cy + 1'b1;
      end
      FACE_Z_NEG: begin
        ok = ok && (cz != '0);
        nz = cz - 1'b1;
      end
      FACE_Z_POS: begin
        ok = ok && (cz < top);
        nz = cz + 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Re-interleave and zero everything when out of domain
  assign nb = spread(nx) | (spread(ny) << 1) | (spread(nz) << 2);

  always_comb begin
    rsp.neighbour_valid = ok;
    rsp.neighbour_code  = ok ? nb : '0;
    rsp.coarser_valid   = ok && (lev != '0);
    rsp.coarser_code    = rsp.coarser_valid ? nb[CODE_W-1:3] : '0;
  end

endmodule

### hdl/mfnp_out_buf.sv
`timescale 1ns / 1ps
// Two-entry result buffer (output register plus skid register) so the
// upstream stall comes from a flop. Depends on mfnp_pkg.
module mfnp_out_buf
  import mfnp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  probe_rsp_t push_data,
  output logic       full,
  output logic       result_valid,
  input  logic       result_stall,
  output probe_rsp_t result
);

  logic       skid_valid;
  probe_rsp_t skid;
  logic       load_out;

  // Output register is free when empty or being taken this cycle
  assign load_out = !result_valid || !result_stall;
  assign full     = skid_valid;

  // Control flops
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (load_out) begin
        result_valid <= skid_valid || push;
        skid_valid   <= 1'b0;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload flops
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (skid_valid) begin
        result <= skid;
      end else if (push) begin
        result <= push_data;
      end
    end else if (push) begin
      skid <= push_data;
    end
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for morton_face_neighbour_probe: directed corner probes, then
// random probes with random sender idle and receiver stall, checked by a predictor.
// Depends on mfnp_pkg and the morton_face_neighbour_probe RTL.
module testbench;
  import mfnp_pkg::*;

  // Face codes with no meaning; the block must answer them with an all-zero result
  localparam logic [FACE_W-1:0] FACE_RSVD_A = 3'd6;
  localparam logic [FACE_W-1:0] FACE_RSVD_B = 3'd7;
  localparam int RANDOM_PROBES = 1600;
  localparam int DRAIN_CYCLES  = 8;

  // Predicts each neighbor lookup and holds the results still owed by the block
  class neighbour_scoreboard;
    probe_rsp_t pending_neighbours[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    static function logic [AXIS_BITS-1:0] gather_axis(logic [CODE_W-1:0] code);
      logic [AXIS_BITS-1:0] crd;
      for (int i = 0; i < AXIS_BITS; i++) crd[i] = code[3*i];
      return crd;
    endfunction

    static function logic [CODE_W-1:0] morton_pack(logic [AXIS_BITS-1:0] x,
                                                   logic [AXIS_BITS-1:0] y,
                                                   logic [AXIS_BITS-1:0] z);
      logic [CODE_W-1:0] code;
      for (int i = 0; i < AXIS_BITS; i++) begin
        code[3*i]   = x[i];
        code[3*i+1] = y[i];
        code[3*i+2] = z[i];
      end
      return code;
    endfunction

    function probe_rsp_t predict_neighbour(probe_req_t req);
      logic [AXIS_BITS-1:0] crd[3];
      logic [AXIS_BITS:0]   top;
      int                   lev;
      int                   axis;
      bit                   step_up;
      bit                   in_domain;
      logic [CODE_W-1:0]    nb;
      probe_rsp_t           rsp;
      // levels above the coordinate width saturate
      lev = (req.node_level > AXIS_BITS) ? AXIS_BITS : int'(req.node_level);
      top = (11'd1 << lev) - 11'd1;
      for (int a = 0; a < 3; a++) crd[a] = gather_axis(req.node_code >> a);
      in_domain = 1'b1;
      for (int a = 0; a < 3; a++) if (crd[a] > top) in_domain = 1'b0;
      axis    = 0;
      step_up = 1'b0;
      case (req.face)
        FACE_X_NEG: begin axis = 0; step_up = 1'b0; end
        FACE_X_POS: begin axis = 0; step_up = 1'b1; end
        FACE_Y_NEG: begin axis = 1; step_up = 1'b0; end
        FACE_Y_POS: begin axis = 1; step_up = 1'b1; end
        FACE_Z_NEG: begin axis = 2; step_up = 1'b0; end
        FACE_Z_POS: begin axis = 2; step_up = 1'b1; end
        default:    in_domain = 1'b0;
      endcase
      // step along the face axis, staying within 0 .. top
      if (in_domain) begin
        if (step_up) begin
          if (crd[axis] >= top) in_domain = 1'b0;
          else crd[axis] = crd[axis] + 1'b1;
        end else begin
          if (crd[axis] == '0) in_domain = 1'b0;
          else crd[axis] = crd[axis] - 1'b1;
        end
      end
      rsp = '0;
      if (in_domain) begin
        nb = morton_pack(crd[0], crd[1], crd[2]);
        rsp.neighbour_code  = nb;
        rsp.neighbour_valid = 1'b1;
        if (lev > 0) begin
          rsp.coarser_code  = nb[CODE_W-1:3];
          rsp.coarser_valid = 1'b1;
        end
      end
      return rsp;
    endfunction

    function void note_probe(probe_req_t req);
      pending_neighbours.insert(pending_neighbours.size(), predict_neighbour(req));
    endfunction

    function void check_result(probe_rsp_t got);
      probe_rsp_t exp;
      if (pending_neighbours.size() == 0) begin
        $error("result with no probe pending: %h", got);
        errors++;
        return;
      end
      exp = pending_neighbours.pop_front();
      if (got.neighbour_code !== exp.neighbour_code) begin
        $error("neighbour_code mismatch: expected %h, actual %h",
               exp.neighbour_code, got.neighbour_code);
        errors++;
      end
      if (got.neighbour_valid !== exp.neighbour_valid) begin
        $error("neighbour_valid mismatch: expected %b, actual %b",
               exp.neighbour_valid, got.neighbour_valid);
        errors++;
      end
      if (got.coarser_code !== exp.coarser_code) begin
        $error("coarser_code mismatch: expected %h, actual %h",
               exp.coarser_code, got.coarser_code);
        errors++;
      end
      if (got.coarser_valid !== exp.coarser_valid) begin
        $error("coarser_valid mismatch: expected %b, actual %b",
               exp.coarser_valid, got.coarser_valid);
        errors++;
      end
    endfunction

    function int pending_count();
      return pending_neighbours.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       probe_valid;
  logic       probe_stall;
  probe_req_t probe;
  logic       result_valid;
  logic       result_stall;
  probe_rsp_t result;

  neighbour_scoreboard sb;
  probe_req_t          directed_probes[$];
  bit                  send_burst;
  bit                  recv_burst;

  morton_face_neighbour_probe u_dut (
    .clk          (clk),
    .rst          (rst),
    .probe_valid  (probe_valid),
    .probe_stall  (probe_stall),
    .probe        (probe),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle length per transaction; bursts switch idling off for a stretch
  function int draw_gap(inout bit burst);
    if ($urandom_range(0, 63) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  function probe_req_t probe_at(int x, int y, int z, int lev, logic [FACE_W-1:0] face);
    probe_req_t p;
    p.node_code  = neighbour_scoreboard::morton_pack(AXIS_BITS'(x), AXIS_BITS'(y),
                                                     AXIS_BITS'(z));
    p.node_level = LEVEL_W'(lev);
    p.face       = face;
    return p;
  endfunction

  // Queue one directed probe
  function void add_directed(probe_req_t p);
    directed_probes.insert(directed_probes.size(), p);
  endfunction

  // Coordinates biased toward the domain boundary
  function logic [AXIS_BITS-1:0] pick_coord(logic [AXIS_BITS:0] top);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return top[AXIS_BITS-1:0];
      2:       return (top > 0) ? AXIS_BITS'(top - 1'b1) : '0;
      3:       return AXIS_BITS'(top & 11'd1);
      default: return AXIS_BITS'($urandom) & top[AXIS_BITS-1:0];
    endcase
  endfunction

  function probe_req_t make_probe();
    probe_req_t         p;
    int                 lev;
    logic [AXIS_BITS:0] top;
    case ($urandom_range(0, 9))
      // raw noise across every field, including unused faces and levels
      0: begin
        p.node_code  = CODE_W'($urandom);
        p.node_level = LEVEL_W'($urandom_range(0, 15));
        p.face       = FACE_W'($urandom_range(0, 7));
      end
      // one coordinate free to exceed the level
      1: begin
        lev = $urandom_range(0, 10);
        top = (11'd1 << lev) - 11'd1;
        p = probe_at(pick_coord(top), $urandom_range(0, 1023), pick_coord(top), lev,
                     FACE_W'($urandom_range(0, 5)));
      end
      // well-formed probe
      default: begin
        lev = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
        top = (11'd1 << lev) - 11'd1;
        p = probe_at(pick_coord(top), pick_coord(top), pick_coord(top), lev,
                     FACE_W'($urandom_range(0, 5)));
      end
    endcase
    return p;
  endfunction

  // Present one transaction after an idle gap and hold it until accepted
  task automatic send_probe(probe_req_t p, int gap);
    if (gap > 0) begin
      @(negedge clk) probe_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    probe_valid <= 1'b1;
    probe       <= p;
    do @(posedge clk); while (probe_stall);
    sb.note_probe(p);
  endtask

  // Hold off the sender until every owed result has been returned
  task automatic wait_drain();
    @(negedge clk) probe_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  // Receiver: random stall before each result transaction
  initial begin
    int n;
    result_stall = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      n = draw_gap(recv_burst);
      repeat (n) @(negedge clk) result_stall <= 1'b1;
      @(negedge clk) result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      sb.check_result(result);
    end
  end

  // Reset, stimulus and verdict
  initial begin
    sb           = new();
    send_burst   = 1'b0;
    recv_burst   = 1'b0;
    rst          = 1'b1;
    probe_valid  = 1'b0;
    probe        = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // level zero, domain corners, saturation, codes beyond level, unused faces
    add_directed(probe_at(0, 0, 0, 0, FACE_X_POS));
    add_directed(probe_at(0, 0, 0, 10, FACE_X_NEG));
    add_directed(probe_at(0, 0, 0, 10, FACE_X_POS));
    add_directed(probe_at(1023, 1023, 1023, 10, FACE_X_POS));
    add_directed(probe_at(1023, 1023, 1023, 10, FACE_X_NEG));
    add_directed(probe_at(1023, 1023, 1023, 10, FACE_Y_NEG));
    add_directed(probe_at(1023, 1023, 1023, 10, FACE_Y_POS));
    add_directed(probe_at(1023, 1023, 1023, 10, FACE_Z_NEG));
    add_directed(probe_at(1023, 1023, 1023, 10, FACE_Z_POS));
    add_directed(probe_at(512, 511, 1, 10, FACE_Y_POS));
    add_directed(probe_at(512, 511, 1, 10, FACE_Z_NEG));
    add_directed(probe_at(1023, 1023, 1023, 15, FACE_X_NEG));
    add_directed(probe_at(0, 5, 1023, 11, FACE_Z_NEG));
    add_directed(probe_at(8, 0, 0, 3, FACE_X_POS));
    add_directed(probe_at(7, 7, 7, 3, FACE_X_NEG));
    add_directed(probe_at(0, 0, 7, 3, FACE_Z_POS));
    add_directed(probe_at(300, 600, 900, 10, FACE_RSVD_A));
    add_directed(probe_at(300, 600, 900, 10, FACE_RSVD_B));
    add_directed(probe_at(0, 1, 0, 1, FACE_Y_NEG));
    add_directed(probe_at(0, 1, 0, 1, FACE_X_POS));
    add_directed(probe_at(0, 1, 0, 1, FACE_Y_POS));
    add_directed(probe_at(0, 0, 0, 15, FACE_RSVD_B));
    foreach (directed_probes[i]) send_probe(directed_probes[i], draw_gap(send_burst));
    wait_drain();

    for (int i = 0; i < RANDOM_PROBES; i++) begin
      if (i % 400 == 200) wait_drain();
      send_probe(make_probe(), draw_gap(send_burst));
    end
    @(negedge clk) probe_valid <= 1'b0;

    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("morton_face_neighbour_probe regression: pass");
    end else begin
      $display("morton_face_neighbour_probe regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("morton_face_neighbour_probe regression: fail");
    $finish;
  end

endmodule
